// ----- hw/rtl/pahp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pahp_pkg;

    // Queue depth between the parser and the output stage
    localparam int unsigned FIFO_DEPTH_DEF = 2;

    localparam int unsigned TDATA_W   = 160;
    localparam int unsigned TUSER_W   = 2;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [31:0] WAV_HDR_LEN = 32'd44;
    localparam logic [31:0] AU_HDR_LEN  = 32'd24;
    localparam logic [31:0] NO_SIZE     = 32'hffff_ffff;
    localparam logic [31:0] POS_MAX     = 32'hffff_ffff;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BODY   = 3'b010,
        PH_DONE   = 3'b100
    } phase_t;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_REJECT  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        FMT_NONE = 2'd0,
        FMT_WAV  = 2'd1,
        FMT_AU   = 2'd2
    } fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IGNORE_SIZE_LIMIT  = 2'd0,
        REG_REQUIRE_LINEAR_PCM = 2'd1
    } cfg_reg_t;

    typedef struct packed {
        logic ignore_size_limit;
        logic require_linear_pcm;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  format;
        logic [31:0] channel_count;
        logic [31:0] rate_hz;
        logic [15:0] sample_bits;
        logic [31:0] au_encoding;
        logic        big_endian_samples;
        logic [31:0] payload_size;
        logic [7:0]  payload_byte;
        logic        last_payload;
    } result_t;

    // Fixed leading bytes of a linear PCM WAV header; bytes 4..7 are not checked
    function automatic logic [7:0] wav_sig_byte(input logic [4:0] idx);
        logic [7:0] v;
        begin
            case (idx)
                5'd0:    v = 8'h52; // R
                5'd1:    v = 8'h49; // I
                5'd2:    v = 8'h46; // F
                5'd3:    v = 8'h46; // F
                5'd8:    v = 8'h57; // W
                5'd9:    v = 8'h41; // A
                5'd10:   v = 8'h56; // V
                5'd11:   v = 8'h45; // E
                5'd12:   v = 8'h66; // f
                5'd13:   v = 8'h6d; // m
                5'd14:   v = 8'h74; // t
                5'd15:   v = 8'h20; // space
                5'd16:   v = 8'h10; // chunk size 16
                5'd20:   v = 8'h01; // format 1
                default: v = 8'h00;
            endcase
            return v;
        end
    endfunction

    function automatic logic [7:0] au_sig_byte(input logic [1:0] idx);
        logic [7:0] v;
        begin
            unique case (idx)
                2'd0:    v = 8'h2e; // .
                2'd1:    v = 8'h73; // s
                2'd2:    v = 8'h6e; // n
                2'd3:    v = 8'h64; // d
                default: v = 8'h00;
            endcase
            return v;
        end
    endfunction

    function automatic logic [15:0] au_bits(input logic [31:0] enc);
        logic [15:0] v;
        begin
            unique case (enc)
                32'd2:   v = 16'd8;
                32'd3:   v = 16'd16;
                32'd4:   v = 16'd24;
                32'd5:   v = 16'd32;
                default: v = 16'd0;
            endcase
            return v;
        end
    endfunction

    // Merge a little-endian byte into lane k of a word
    function automatic logic [31:0] le_put(input logic [31:0] acc, input logic [7:0] b,
                                           input logic [1:0] k);
        begin
            return acc | ({24'd0, b} << {k, 3'b000});
        end
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/pcm_audio_header_parser.sv -----
// Result path: the queue is written on the edge that takes a result's byte, and the output
//   register then loads that result from the queue head and raises tvalid.
// Throughput: one byte per cycle sustained. While the master stalls, the queue and the output
//   register hold three results, then s_axis_tready drops until the queue frees an entry.
// Reset: rst_n is asynchronous, active low; it puts the parser in the header phase with all
//   fields zero, empties the queue and clears output valid and both configuration bits.
`timescale 1ns / 1ps
`default_nettype none

module pcm_audio_header_parser
    import pahp_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    // Byte stream in
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [7:0]            s_axis_tdata,   // [7:0] file_byte
    input  wire logic                  s_axis_tlast,   // end_of_file

    // Result stream out
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // [1:0] format, [33:2] channel_count, [65:34] rate_hz, [81:66] sample_bits,
    // [113:82] au_encoding, [114] big_endian_samples, [146:115] payload_size,
    // [154:147] payload_byte, [159:155] zero
    output logic [TDATA_W-1:0]         m_axis_tdata,
    output logic [TUSER_W-1:0]         m_axis_tuser,   // [1:0] kind
    output logic                       m_axis_tlast,   // last_payload

    // Configuration writes
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic                  cfg_data
);

    cfg_t    cfg_reg, cfg_next;
    logic    in_fire;
    logic    fifo_full;
    logic    push;
    result_t push_data;
    logic    pop;
    logic    head_valid;
    result_t head_data;

    // Configuration is taken every cycle; writes to an unknown index are dropped
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_IGNORE_SIZE_LIMIT:  cfg_next.ignore_size_limit  = cfg_data;
                REG_REQUIRE_LINEAR_PCM: cfg_next.require_linear_pcm = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

    // Hold off the source only when the queue is full
    assign s_axis_tready = !fifo_full;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Front: parse each byte, update header state, produce at most one result
    pahp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_fire   (in_fire),
        .in_byte   (s_axis_tdata),
        .in_eof    (s_axis_tlast),
        .push      (push),
        .push_data (push_data)
    );

    // Queue: decouple the parser from a stalled master
    pahp_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data)
    );

    // Back: register the beat and pack it onto the master side
    pahp_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_valid    (head_valid),
        .head_data     (head_data),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/pahp_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pahp_front
    import pahp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire logic    in_fire,
    input  wire logic [7:0] in_byte,
    input  wire logic    in_eof,
    output logic         push,
    output result_t      push_data
);

    phase_t      phase_reg, phase_next;
    logic [1:0]  fmt_reg, fmt_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic [31:0] enc_reg, enc_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] offs_reg, offs_next;
    logic [31:0] ext_reg, ext_next;

    logic        reject;
    logic        hdr_done;
    logic        limited;
    logic [31:0] bits_wide;

    always_comb
    begin
        phase_next = phase_reg;
        fmt_next   = fmt_reg;
        pos_next   = pos_reg;
        chan_next  = chan_reg;
        rate_next  = rate_reg;
        bits_next  = bits_reg;
        enc_next   = enc_reg;
        size_next  = size_reg;
        offs_next  = offs_reg;
        ext_next   = ext_reg;
        reject     = 1'b0;
        hdr_done   = 1'b0;
        limited    = 1'b0;
        bits_wide  = 32'd0;
        push       = 1'b0;
        push_data  = '0;

        if (in_fire)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (pos_reg == 32'd0)
                    begin
                        if (in_byte == wav_sig_byte(5'd0))
                            fmt_next = FMT_WAV;
                        else if (in_byte == au_sig_byte(2'd0))
                            fmt_next = FMT_AU;
                        else
                            reject = 1'b1;
                    end
                    else if (fmt_reg == FMT_WAV)
                    begin
                        if (pos_reg < 32'd22 && (pos_reg < 32'd4 || pos_reg > 32'd7)
                            && in_byte != wav_sig_byte(pos_reg[4:0]))
                            reject = 1'b1;
                        else if (pos_reg == 32'd22 || pos_reg == 32'd23)
                            chan_next = le_put(chan_reg, in_byte, {1'b0, pos_reg[0]});
                        else if (pos_reg >= 32'd24 && pos_reg <= 32'd27)
                            rate_next = le_put(rate_reg, in_byte, pos_reg[1:0]);
                        else if (pos_reg == 32'd34 || pos_reg == 32'd35)
                        begin
                            bits_wide = le_put({16'd0, bits_reg}, in_byte,
                                               {1'b0, pos_reg[0]});
                            bits_next = bits_wide[15:0];
                        end
                        else if (pos_reg >= 32'd40 && pos_reg <= 32'd43)
                            size_next = le_put(size_reg, in_byte, pos_reg[1:0]);

                        if (!reject && pos_reg == WAV_HDR_LEN - 32'd1)
                        begin
                            hdr_done                     = 1'b1;
                            push                         = 1'b1;
                            push_data.kind               = KIND_HEADER;
                            push_data.format             = FMT_WAV;
                            push_data.channel_count      = chan_next;
                            push_data.rate_hz            = rate_next;
                            push_data.sample_bits        = bits_next;
                            push_data.payload_size       = size_next;
                            offs_next                    = WAV_HDR_LEN;
                            phase_next                   = PH_BODY;
                        end
                    end
                    else
                    begin
                        if (pos_reg < 32'd4)
                        begin
                            if (in_byte != au_sig_byte(pos_reg[1:0]))
                                reject = 1'b1;
                        end
                        else if (pos_reg < 32'd8)
                            offs_next = {offs_reg[23:0], in_byte};
                        else if (pos_reg < 32'd12)
                            size_next = {size_reg[23:0], in_byte};
                        else if (pos_reg < 32'd16)
                            enc_next = {enc_reg[23:0], in_byte};
                        else if (pos_reg < 32'd20)
                            rate_next = {rate_reg[23:0], in_byte};
                        else
                            chan_next = {chan_reg[23:0], in_byte};

                        if (!reject && pos_reg == AU_HDR_LEN - 32'd1)
                        begin
                            bits_next = au_bits(enc_next);
                            if (size_next == NO_SIZE)
                                size_next = 32'd0;
                            if (offs_next < AU_HDR_LEN)
                                offs_next = AU_HDR_LEN;
                            if (cfg.require_linear_pcm && bits_next == 16'd0)
                                reject = 1'b1;
                            else
                            begin
                                hdr_done                     = 1'b1;
                                push                         = 1'b1;
                                push_data.kind               = KIND_HEADER;
                                push_data.format             = FMT_AU;
                                push_data.channel_count      = chan_next;
                                push_data.rate_hz            = rate_next;
                                push_data.sample_bits        = bits_next;
                                push_data.au_encoding        = enc_next;
                                push_data.big_endian_samples = 1'b1;
                                push_data.payload_size       = size_next;
                                phase_next                   = PH_BODY;
                            end
                        end
                    end

                    // Short header: file ends before the header is complete
                    if (!reject && !hdr_done && in_eof)
                        reject = 1'b1;

                    if (reject)
                    begin
                        push           = 1'b1;
                        push_data      = '0;
                        push_data.kind = KIND_REJECT;
                        phase_next     = PH_DONE;
                    end
                end

                PH_BODY:
                begin
                    if (pos_reg >= offs_reg)
                    begin
                        limited = (size_reg != 32'd0) && !cfg.ignore_size_limit;
                        if (!limited || ext_reg < size_reg)
                        begin
                            if (ext_reg != POS_MAX)
                                ext_next = ext_reg + 32'd1;
                            push                   = 1'b1;
                            push_data.kind         = KIND_PAYLOAD;
                            push_data.format       = fmt_reg;
                            push_data.payload_byte = in_byte;
                            push_data.last_payload = in_eof
                                                     || (limited && ext_next == size_reg);
                        end
                    end
                end

                PH_DONE:
                begin
                    // drop bytes until end of file
                end

                default:
                begin
                end
            endcase

            if (pos_reg != POS_MAX)
                pos_next = pos_reg + 32'd1;

            // End of file: start the next file from clean state
            if (in_eof)
            begin
                phase_next = PH_HEADER;
                fmt_next   = FMT_NONE;
                pos_next   = 32'd0;
                chan_next  = 32'd0;
                rate_next  = 32'd0;
                bits_next  = 16'd0;
                enc_next   = 32'd0;
                size_next  = 32'd0;
                offs_next  = 32'd0;
                ext_next   = 32'd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            fmt_reg   <= FMT_NONE;
            pos_reg   <= 32'd0;
            chan_reg  <= 32'd0;
            rate_reg  <= 32'd0;
            bits_reg  <= 16'd0;
            enc_reg   <= 32'd0;
            size_reg  <= 32'd0;
            offs_reg  <= 32'd0;
            ext_reg   <= 32'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            fmt_reg   <= fmt_next;
            pos_reg   <= pos_next;
            chan_reg  <= chan_next;
            rate_reg  <= rate_next;
            bits_reg  <= bits_next;
            enc_reg   <= enc_next;
            size_reg  <= size_next;
            offs_reg  <= offs_next;
            ext_reg   <= ext_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pahp_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pahp_fifo
    import pahp_pkg::*;
#(
    parameter int unsigned DEPTH = FIFO_DEPTH_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire result_t push_data,
    output logic         full,
    input  wire logic    pop,
    output logic         head_valid,
    output result_t      head_data
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    result_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               do_push;
    logic               do_pop;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            cnt_next = cnt_reg + 1'b1;
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ----- hw/rtl/pahp_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pahp_back
    import pahp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              head_valid,
    input  wire result_t           head_data,
    output logic                   pop,
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [TDATA_W-1:0]     m_axis_tdata,
    output logic [TUSER_W-1:0]     m_axis_tuser,
    output logic                   m_axis_tlast
);

    logic    valid_reg, valid_next;
    result_t data_reg;
    logic    take;

    // Load a new beat when the register is empty or its beat leaves this cycle
    assign take = !valid_reg || m_axis_tready;
    assign pop  = head_valid && take;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = head_valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= head_data;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = data_reg.kind;
    assign m_axis_tlast  = data_reg.last_payload;
    assign m_axis_tdata  = {5'd0,
                            data_reg.payload_byte,
                            data_reg.payload_size,
                            data_reg.big_endian_samples,
                            data_reg.au_encoding,
                            data_reg.sample_bits,
                            data_reg.rate_hz,
                            data_reg.channel_count,
                            data_reg.format};

endmodule

`default_nettype wire
